@@ rtl/nccm_pkg.sv @@
// Package for the neighbor color contrast block: payload structs, job descriptor and FSM states.
// No dependencies.
`default_nettype none
package nccm_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [10:0] pos_x;
    logic [11:0] pos_y;
    logic [17:0] max_sq_distance;
    logic [12:0] distance_fixed;
    logic        run_last;
    logic        frame_last;
  } out_item_t;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  // One result job: window snapshot plus position and neighbor mask.
  typedef struct packed {
    logic [8:0][23:0] win;
    logic [1:0]       wr;
    logic [1:0]       wc;
    logic [10:0]      px;
    logic [11:0]      py;
    logic [7:0]       nmask;
    logic             run_last;
    logic             frame_last;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE, BK_DIST, BK_SQRT, BK_OUT
  } bk_state_t;

endpackage
`default_nettype wire

@@ rtl/neighbor_color_contrast_max_core.sv @@
// Streaming 3x3 max color contrast: the front end handles each raster pixel in two phases
// (line-store read, then window shift); the back end handles each result in steps
// (taking the job while idle, 8 neighbor compares, 13 square-root steps, an output state
// held until out_ready is high), so the back end sets the sustained rate. The front end holds a
// pixel's jobs until the back end takes them and accepts the next pixel after the last one.
`default_nettype none
module neighbor_color_contrast_max_core
  import nccm_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  logic job_valid, job_ready;
  job_t job;

  nccm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .cfg_we, .cfg_index, .cfg_data,
    .job_valid, .job_ready, .job);

  nccm_back u_back (
    .clk, .rst_n, .job_valid, .job_ready, .job, .out_valid, .out_ready, .out_data);
endmodule
`default_nettype wire

@@ rtl/nccm_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nccm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/nccm_front.sv @@
// Front end: counts position, reads line stores, shifts the 3x3 window and issues jobs.
// Depends on nccm_pkg and nccm_ram.
`default_nettype none
module nccm_front
  import nccm_pkg::*;
#(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire logic [12:0] cfg_data,
  output logic           job_valid,
  input  wire logic      job_ready,
  output job_t           job
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(MAX_HEIGHT);

  logic [11:0] width_r;
  logic [12:0] height_r;
  logic [AW:0] w_eff;
  logic [HW:0] h_eff;
  logic [AW-1:0] col_r;
  logic [HW-1:0] row_r;
  logic [AW-1:0] pix_col_r;  // position of the pixel whose jobs are issued
  logic [HW-1:0] pix_row_r;
  logic          busy_r;    // phase 2: line-store data available
  logic [23:0]   pix_r;
  logic [8:0][23:0] win_r;
  logic [3:0]    kinds_r;
  logic [23:0]   old_q, new_q;
  logic [AW-1:0] c;
  logic [HW-1:0] r;
  logic          row_end, last_row;

  // Saturate the configured frame size; a size of zero counts as one
  always_comb begin
    if (width_r == 12'd0) w_eff = (AW+1)'(1);
    else if ({20'd0, width_r} > 32'(MAX_WIDTH)) w_eff = (AW+1)'(MAX_WIDTH);
    else w_eff = (AW+1)'(width_r);
    if (height_r == 13'd0) h_eff = (HW+1)'(1);
    else if ({19'd0, height_r} > 32'(MAX_HEIGHT)) h_eff = (HW+1)'(MAX_HEIGHT);
    else h_eff = (HW+1)'(height_r);
  end

  // Wrap a stale position back to the frame origin
  always_comb begin
    if ({1'b0, col_r} >= w_eff || {1'b0, row_r} >= h_eff) begin
      c = '0; r = '0;
    end else begin
      c = col_r; r = row_r;
    end
    row_end  = ({1'b0, c} + 1'b1) == w_eff;
    last_row = ({1'b0, r} + 1'b1) == h_eff;
  end

  logic accept, store_we;
  assign in_ready = !busy_r && (kinds_r == 4'd0);
  assign accept   = in_valid && in_ready;
  assign store_we = busy_r;

  nccm_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_older (
    .clk, .we(store_we), .waddr(c), .wdata(new_q), .raddr(c), .rdata(old_q));
  nccm_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_newer (
    .clk, .we(store_we), .waddr(c), .wdata(pix_r), .raddr(c), .rdata(new_q));

  // Kind select: lowest pending job kind
  logic [1:0] kind;
  always_comb begin
    kind = 2'd3;
    if (kinds_r[0]) kind = 2'd0;
    else if (kinds_r[1]) kind = 2'd1;
    else if (kinds_r[2]) kind = 2'd2;
  end
  logic [3:0] kinds_left;
  always_comb begin
    kinds_left = kinds_r;
    kinds_left[kind] = 1'b0;
  end

  // Build the job for the selected kind
  logic [AW-1:0] pc;
  logic [HW-1:0] pr;
  logic          last_col_r, last_row_r;
  always_comb begin
    job = '0;
    job.win = win_r;
    job.wr  = (kind[1]) ? 2'd2 : 2'd1;
    job.wc  = (kind[0]) ? 2'd2 : 2'd1;
    pc = kind[0] ? pix_col_r : pix_col_r - 1'b1;
    pr = kind[1] ? pix_row_r : pix_row_r - 1'b1;
    job.px = 11'(pc);
    job.py = 12'(pr);
    // Neighbor mask in raster order of (dr,dc), center skipped
    job.nmask[0] = pr != 0 && pc != 0;
    job.nmask[1] = pr != 0;
    job.nmask[2] = pr != 0 && !(kind[0]);
    job.nmask[3] = pc != 0;
    job.nmask[4] = !(kind[0]);
    job.nmask[5] = !(kind[1]) && pc != 0;
    job.nmask[6] = !(kind[1]);
    job.nmask[7] = !(kind[1]) && !(kind[0]);
    // Right/bottom neighbors also exist only inside the frame
    if (kind[0] && last_col_r) begin
      job.nmask[2] = 1'b0; job.nmask[4] = 1'b0; job.nmask[7] = 1'b0;
    end
    if (kind[1] && last_row_r) begin
      job.nmask[5] = 1'b0; job.nmask[6] = 1'b0; job.nmask[7] = 1'b0;
    end
    job.run_last   = (kinds_left == 4'd0);
    job.frame_last = (kind == 2'd3);
  end
  assign job_valid = (kinds_r != 4'd0);

  // Position, window and job issue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= 12'd640; height_r <= 13'd480;
      col_r <= '0; row_r <= '0; busy_r <= 1'b0; kinds_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) width_r <= cfg_data[11:0];
        else height_r <= cfg_data;
        col_r <= '0; row_r <= '0;
      end
      if (accept) begin
        busy_r <= 1'b1;
        pix_r  <= in_data;
        col_r  <= c; row_r <= r;
        pix_col_r <= c; pix_row_r <= r;
        last_col_r <= row_end; last_row_r <= last_row;
      end
      if (busy_r) begin
        busy_r <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          win_r[i*3+0] <= win_r[i*3+1];
          win_r[i*3+1] <= win_r[i*3+2];
        end
        win_r[2] <= old_q; win_r[5] <= new_q; win_r[8] <= pix_r;
        kinds_r[0] <= col_r != 0 && row_r != 0;
        kinds_r[1] <= last_col_r && row_r != 0;
        kinds_r[2] <= last_row_r && col_r != 0;
        kinds_r[3] <= last_row_r && last_col_r;
        if (last_col_r) begin
          col_r <= '0;
          row_r <= last_row_r ? '0 : row_r + 1'b1;
        end else col_r <= col_r + 1'b1;
      end
      if (job_valid && job_ready) kinds_r <= kinds_left;
    end
  end
endmodule
`default_nettype wire

@@ rtl/nccm_back.sv @@
// Back end: per job, scan neighbors for max squared distance, then integer square root.
// Depends on nccm_pkg.
`default_nettype none
module nccm_back
  import nccm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  job_valid,
  output logic       job_ready,
  input  wire job_t  job,
  output logic       out_valid,
  input  wire logic  out_ready,
  output out_item_t  out_data
);
  bk_state_t state_r, state_nxt;
  job_t      job_r;
  logic [2:0]  idx_r;
  logic [17:0] best_r;
  logic [25:0] rem_r;
  logic [12:0] root_r;
  logic [3:0]  step_r;

  // Neighbor window index for offset idx around center (wr, wc)
  logic [1:0] roff, coff;
  logic [3:0] wi;
  logic [23:0] nb, ce;
  logic signed [8:0] dr, dg, db;
  logic [17:0] sq_now;
  always_comb begin
    case (idx_r)
      3'd0: begin roff = 2'd0; coff = 2'd0; end
      3'd1: begin roff = 2'd0; coff = 2'd1; end
      3'd2: begin roff = 2'd0; coff = 2'd2; end
      3'd3: begin roff = 2'd1; coff = 2'd0; end
      3'd4: begin roff = 2'd1; coff = 2'd2; end
      3'd5: begin roff = 2'd2; coff = 2'd0; end
      3'd6: begin roff = 2'd2; coff = 2'd1; end
      default: begin roff = 2'd2; coff = 2'd2; end
    endcase
    wi = 4'(({2'b00, job_r.wr} + {2'b00, roff} - 4'd1) * 4'd3
            + {2'b00, job_r.wc} + {2'b00, coff} - 4'd1);
    nb = job_r.win[wi];
    ce = job_r.win[4'(job_r.wr * 3 + job_r.wc)];
    dr = 9'(nb[23:16]) - 9'(ce[23:16]);
    dg = 9'(nb[15:8])  - 9'(ce[15:8]);
    db = 9'(nb[7:0])   - 9'(ce[7:0]);
    sq_now = 18'(dr * dr) + 18'(dg * dg) + 18'(db * db);
  end

  // Square root step: one result bit per cycle over value * 256
  logic [27:0] trial;
  logic [25:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r[23:0], 2'b00} | 26'(({best_r, 8'd0} >> (2 * step_r)) & 26'd3);
    trial  = {13'd0, root_r, 2'b01};
  end

  always_comb begin
    state_nxt = state_r;
    job_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) state_nxt = BK_DIST;
      end
      BK_DIST: if (idx_r == 3'd7) state_nxt = BK_SQRT;
      BK_SQRT: if (step_r == 4'd0) state_nxt = BK_OUT;
      BK_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else state_r <= state_nxt;
    case (state_r)
      BK_IDLE: begin
        job_r <= job; idx_r <= '0; best_r <= '0;
        rem_r <= '0; root_r <= '0; step_r <= 4'd12;
      end
      BK_DIST: begin
        if (job_r.nmask[idx_r] && sq_now > best_r) best_r <= sq_now;
        idx_r <= idx_r + 1'b1;
      end
      BK_SQRT: begin
        if ({2'b00, rem_sh} >= trial) begin
          rem_r  <= 26'({2'b00, rem_sh} - trial);
          root_r <= {root_r[11:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[11:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_data.pos_x           = job_r.px;
    out_data.pos_y           = job_r.py;
    out_data.max_sq_distance = best_r;
    out_data.distance_fixed  = root_r;
    out_data.run_last        = job_r.run_last;
    out_data.frame_last      = job_r.frame_last;
  end
endmodule
`default_nettype wire
